### rtl/core/hqs_pkg.sv
// package: shared constants, codes and types of the hybrid quicksort engine
`timescale 1ns / 1ps
`default_nettype none
package hqs_pkg;

    localparam int DEPTH_DEF       = 4096;
    localparam int QUEUE_DEPTH_DEF = 2048;
    localparam int DATA_W          = 32;
    localparam int CUTOFF_W        = 13;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 2;
    localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 13'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_SORT   = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [26:0] {
        S_IDLE       = 27'd1 << 0,
        S_RD_WAIT    = 27'd1 << 1,
        S_START      = 27'd1 << 2,
        S_SEG        = 27'd1 << 3,
        S_INS_INIT   = 27'd1 << 4,
        S_INS_OUTER  = 27'd1 << 5,
        S_INS_V      = 27'd1 << 6,
        S_INS_CHK    = 27'd1 << 7,
        S_INS_CMP    = 27'd1 << 8,
        S_INS_PUT    = 27'd1 << 9,
        S_PI_INIT    = 27'd1 << 10,
        S_PI_PIV     = 27'd1 << 11,
        S_SCAN_I     = 27'd1 << 12,
        S_SCAN_I_CMP = 27'd1 << 13,
        S_SCAN_J     = 27'd1 << 14,
        S_SCAN_J_CMP = 27'd1 << 15,
        S_SWAP       = 27'd1 << 16,
        S_SWAP2      = 27'd1 << 17,
        S_SCAN_END   = 27'd1 << 18,
        S_PEND_CMP   = 27'd1 << 19,
        S_PREAD      = 27'd1 << 20,
        S_PSWAP      = 27'd1 << 21,
        S_PSWAP2     = 27'd1 << 22,
        S_SPLIT      = 27'd1 << 23,
        S_POP        = 27'd1 << 24,
        S_POP_W      = 27'd1 << 25,
        S_DONE       = 27'd1 << 26
    } step_t;

    typedef struct packed {
        step_t step;
        logic  accept;
    } cmd_t;

    typedef struct packed {
        logic count_lt2;
        logic seg_live;
        logic seg_small;
        logic ins_done;
        logic ins_more;
        logic ins_shift;
        logic i_lt_j;
        logic rd_lt_pk;
        logic rd_gt_pk;
        logic rd_ge_pk;
        logic left;
        logic right;
        logic q_full;
        logic q_empty;
        logic ret_seg;
    } flags_t;

endpackage
`default_nettype wire

### rtl/core/hqs_if.sv
// interfaces: request, response and cutoff write channels
`timescale 1ns / 1ps
`default_nettype none
interface hqs_req_if #(parameter int IW = $clog2(hqs_pkg::DEPTH_DEF)) ();
    logic                        valid;
    logic                        ready;
    logic [hqs_pkg::OP_W-1:0]    operation;
    logic signed [hqs_pkg::DATA_W-1:0] value;
    logic [IW-1:0]               index;
    modport source (output valid, operation, value, index, input ready);
    modport sink (input valid, operation, value, index, output ready);
endinterface

interface hqs_rsp_if #(parameter int CW = $clog2(hqs_pkg::DEPTH_DEF + 1)) ();
    logic                        valid;
    logic                        ready;
    logic signed [hqs_pkg::DATA_W-1:0] data;
    logic [hqs_pkg::STATUS_W-1:0] status;
    logic [CW-1:0]               element_count;
    modport source (output valid, data, status, element_count, input ready);
    modport sink (input valid, data, status, element_count, output ready);
endinterface

interface hqs_cfg_if ();
    logic                          valid;
    logic                          ready;
    logic [hqs_pkg::CUTOFF_W-1:0]  data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/core/hybrid_quicksort_engine.sv
// top level: hybrid quicksort engine over an on-chip element store
//
//  channel  role    beat
//  req      sink    operation, value, index
//  rsp      source  data, status, element_count
//  cfg      sink    cutoff size
//
// append and clear: one beat per cycle; read: two cycles, store read is registered
// sort: ready held low while one store port walks the segments, about 2 cycles
//   per compared element plus 2 per swap, result beat valid two cycles after the ring is empty
// reset: no clearing pass, store contents are only read below the element count
// a held response beat stalls request intake, cfg is always ready
`timescale 1ns / 1ps
`default_nettype none
module hybrid_quicksort_engine #(
    parameter int DEPTH       = hqs_pkg::DEPTH_DEF,
    parameter int QUEUE_DEPTH = hqs_pkg::QUEUE_DEPTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    hqs_req_if.sink    req,
    hqs_rsp_if.source  rsp,
    hqs_cfg_if.sink    cfg
);
    import hqs_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t   cmd;
    flags_t flags;

    assign cfg.ready = 1'b1;

    hqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .operation (req.operation),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    hqs_datapath #(
        .DEPTH       (DEPTH),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IW          (IW),
        .CW          (CW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .flags         (flags),
        .operation     (req.operation),
        .value         (req.value),
        .index         (req.index[IW-1:0]),
        .cfg_we        (cfg.valid),
        .cfg_data      (cfg.data),
        .data          (rsp.data),
        .status        (rsp.status),
        .element_count (rsp.element_count)
    );
endmodule
`default_nettype wire

### rtl/core/hqs_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module hqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### rtl/core/hqs_datapath.sv
// datapath: element store, segment ring, scan registers and result register
`timescale 1ns / 1ps
`default_nettype none
module hqs_datapath #(
    parameter int DEPTH       = hqs_pkg::DEPTH_DEF,
    parameter int QUEUE_DEPTH = hqs_pkg::QUEUE_DEPTH_DEF,
    parameter int IW          = $clog2(DEPTH),
    parameter int CW          = $clog2(DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hqs_pkg::cmd_t                      cmd,
    output hqs_pkg::flags_t                    flags,
    input  logic [hqs_pkg::OP_W-1:0]           operation,
    input  logic signed [hqs_pkg::DATA_W-1:0]  value,
    input  logic [IW-1:0]                      index,
    input  logic                               cfg_we,
    input  logic [hqs_pkg::CUTOFF_W-1:0]       cfg_data,
    output logic signed [hqs_pkg::DATA_W-1:0]  data,
    output logic [hqs_pkg::STATUS_W-1:0]       status,
    output logic [CW-1:0]                      element_count
);
    import hqs_pkg::*;

    localparam int XW  = IW + 1;
    localparam int LW  = (XW > CUTOFF_W) ? XW : CUTOFF_W;
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QAW-1:0] QLAST = QAW'(QUEUE_DEPTH - 1);

    logic [CW-1:0]       count_reg;
    logic [CUTOFF_W-1:0] cutoff_reg;
    logic [XW-1:0]       lo_reg, hi_reg, i_reg, j_reg, p_reg, ins_lo_reg, ins_hi_reg;
    logic signed [DATA_W-1:0] pk_reg, v_reg, ei_reg, ej_reg, ep_reg;
    logic [QAW-1:0]      qhead_reg, qtail_reg;
    logic [QFW-1:0]      qfill_reg;
    logic                ret_seg_reg, rd_ok_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CW-1:0]       ecount_reg;

    logic signed [DATA_W-1:0] rdata;
    logic [DATA_W-1:0]   rdata_raw, wdata;
    logic                we;
    logic [XW-1:0]       waddr, raddr;
    logic [2*IW-1:0]     qrdata;
    logic                qwe;
    logic [XW-1:0]       push_lo, push_hi, seg_len;
    logic                left_smaller, room;
    op_t                 op;

    assign op    = op_t'(operation);
    assign rdata = $signed(rdata_raw);
    assign room  = count_reg < CW'(DEPTH);

    assign seg_len      = hi_reg - lo_reg + XW'(1);
    assign left_smaller = (p_reg - lo_reg) < (hi_reg - p_reg);
    assign push_lo      = left_smaller ? lo_reg : p_reg + XW'(1);
    assign push_hi      = left_smaller ? p_reg - XW'(1) : hi_reg;

    always_comb
    begin
        flags.count_lt2 = count_reg < CW'(2);
        flags.seg_live  = hi_reg > lo_reg;
        flags.seg_small = LW'(seg_len) < LW'(cutoff_reg);
        flags.ins_done  = i_reg > ins_hi_reg;
        flags.ins_more  = j_reg > ins_lo_reg;
        flags.ins_shift = rdata > v_reg;
        flags.i_lt_j    = i_reg < j_reg;
        flags.rd_lt_pk  = rdata < pk_reg;
        flags.rd_gt_pk  = rdata > pk_reg;
        flags.rd_ge_pk  = rdata >= pk_reg;
        flags.left      = p_reg > lo_reg + XW'(1);
        flags.right     = p_reg + XW'(1) < hi_reg;
        flags.q_full    = qfill_reg >= QFW'(QUEUE_DEPTH);
        flags.q_empty   = qfill_reg == '0;
        flags.ret_seg   = ret_seg_reg;
    end

    always_comb
    begin
        raddr = '0;
        waddr = '0;
        wdata = '0;
        we    = 1'b0;
        case (cmd.step)
            S_IDLE:
            begin
                raddr = XW'(index);
                waddr = XW'(count_reg);
                wdata = value;
                we    = cmd.accept && (op == OP_APPEND) && room;
            end
            S_INS_OUTER: raddr = i_reg;
            S_INS_CHK:   raddr = j_reg - XW'(1);
            S_INS_CMP:
            begin
                waddr = j_reg;
                wdata = rdata;
                we    = flags.ins_shift;
            end
            S_INS_PUT:
            begin
                waddr = j_reg;
                wdata = v_reg;
                we    = 1'b1;
            end
            S_PI_INIT:  raddr = hi_reg;
            S_SCAN_I:   raddr = i_reg;
            S_SCAN_J:   raddr = j_reg;
            S_SCAN_END: raddr = i_reg;
            S_PEND_CMP: raddr = i_reg + XW'(1);
            S_SWAP:
            begin
                waddr = i_reg;
                wdata = ej_reg;
                we    = 1'b1;
            end
            S_SWAP2:
            begin
                waddr = j_reg;
                wdata = ei_reg;
                we    = 1'b1;
            end
            S_PSWAP:
            begin
                waddr = p_reg;
                wdata = pk_reg;
                we    = 1'b1;
            end
            S_PSWAP2:
            begin
                waddr = hi_reg;
                wdata = ep_reg;
                we    = 1'b1;
            end
            default: we = 1'b0;
        endcase
    end

    assign qwe = (cmd.step == S_SPLIT) && flags.left && flags.right && !flags.q_full;

    hqs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .AW(IW)) u_store (
        .clk     (clk),
        .wr_en   (we),
        .wr_addr (waddr[IW-1:0]),
        .wr_data (wdata),
        .rd_addr (raddr[IW-1:0]),
        .rd_data (rdata_raw)
    );

    hqs_ram #(.WIDTH(2 * IW), .DEPTH(QUEUE_DEPTH), .AW(QAW)) u_ring (
        .clk     (clk),
        .wr_en   (qwe),
        .wr_addr (qtail_reg),
        .wr_data ({push_lo[IW-1:0], push_hi[IW-1:0]}),
        .rd_addr (qhead_reg),
        .rd_data (qrdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            cutoff_reg  <= CUTOFF_RST;
            lo_reg      <= '0;
            hi_reg      <= '0;
            ins_lo_reg  <= '0;
            ins_hi_reg  <= '0;
            qhead_reg   <= '0;
            qtail_reg   <= '0;
            qfill_reg   <= '0;
            ret_seg_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cutoff_reg <= cfg_data;
            end
            case (cmd.step)
                S_IDLE:
                begin
                    if (cmd.accept && op == OP_APPEND && room)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    else if (cmd.accept && op == OP_CLEAR)
                    begin
                        count_reg <= '0;
                    end
                end
                S_START:
                begin
                    lo_reg <= '0;
                    hi_reg <= XW'(count_reg - CW'(1));
                end
                S_SEG:
                begin
                    ins_lo_reg  <= lo_reg;
                    ins_hi_reg  <= hi_reg;
                    ret_seg_reg <= 1'b0;
                end
                S_SPLIT:
                begin
                    if (flags.left && flags.right)
                    begin
                        ins_lo_reg  <= push_lo;
                        ins_hi_reg  <= push_hi;
                        ret_seg_reg <= 1'b1;
                        if (!flags.q_full)
                        begin
                            qtail_reg <= (qtail_reg == QLAST) ? '0 : qtail_reg + QAW'(1);
                            qfill_reg <= qfill_reg + QFW'(1);
                        end
                        if (left_smaller)
                        begin
                            lo_reg <= p_reg + XW'(1);
                        end
                        else
                        begin
                            hi_reg <= p_reg - XW'(1);
                        end
                    end
                    else if (flags.left)
                    begin
                        hi_reg <= p_reg - XW'(1);
                    end
                    else if (flags.right)
                    begin
                        lo_reg <= p_reg + XW'(1);
                    end
                end
                S_POP_W:
                begin
                    lo_reg    <= XW'(qrdata[2*IW-1:IW]);
                    hi_reg    <= XW'(qrdata[IW-1:0]);
                    qhead_reg <= (qhead_reg == QLAST) ? '0 : qhead_reg + QAW'(1);
                    qfill_reg <= qfill_reg - QFW'(1);
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.step)
            S_IDLE:
            begin
                rd_ok_reg <= CW'(index) < count_reg;
                if (cmd.accept && op == OP_APPEND)
                begin
                    data_reg   <= '0;
                    status_reg <= room ? ST_OK : ST_FULL;
                    ecount_reg <= room ? count_reg + CW'(1) : count_reg;
                end
                else if (cmd.accept && op == OP_CLEAR)
                begin
                    data_reg   <= '0;
                    status_reg <= ST_OK;
                    ecount_reg <= '0;
                end
            end
            S_RD_WAIT:
            begin
                data_reg   <= rd_ok_reg ? rdata : '0;
                status_reg <= rd_ok_reg ? ST_OK : ST_RANGE;
                ecount_reg <= count_reg;
            end
            S_DONE:
            begin
                data_reg   <= '0;
                status_reg <= ST_OK;
                ecount_reg <= count_reg;
            end
            S_INS_INIT: i_reg <= ins_lo_reg + XW'(1);
            S_INS_V:
            begin
                v_reg <= rdata;
                j_reg <= i_reg;
            end
            S_INS_CMP:
            begin
                if (flags.ins_shift)
                begin
                    j_reg <= j_reg - XW'(1);
                end
            end
            S_INS_PUT: i_reg <= i_reg + XW'(1);
            S_PI_PIV:
            begin
                pk_reg <= rdata;
                i_reg  <= lo_reg;
                j_reg  <= hi_reg - XW'(1);
            end
            S_SCAN_I_CMP:
            begin
                ei_reg <= rdata;
                if (flags.rd_lt_pk)
                begin
                    i_reg <= i_reg + XW'(1);
                end
            end
            S_SCAN_J_CMP:
            begin
                ej_reg <= rdata;
                if (flags.rd_gt_pk)
                begin
                    j_reg <= j_reg - XW'(1);
                end
            end
            S_SWAP2:
            begin
                i_reg <= i_reg + XW'(1);
                j_reg <= j_reg - XW'(1);
            end
            S_PEND_CMP:
            begin
                p_reg  <= flags.rd_ge_pk ? i_reg : i_reg + XW'(1);
                ep_reg <= rdata;
            end
            S_PREAD: ep_reg <= rdata;
            default: ep_reg <= ep_reg;
        endcase
    end

    assign data          = data_reg;
    assign status        = status_reg;
    assign element_count = ecount_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count beyond store depth");
    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qfill_reg <= QFW'(QUEUE_DEPTH))
        else $error("segment ring overfilled");
    a_ring_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == S_IDLE) |-> (qfill_reg == '0))
        else $error("segment ring not empty while idle");
`endif
endmodule
`default_nettype wire

### rtl/core/hqs_ctrl.sv
// controller: operation sequencer and handshake control
`timescale 1ns / 1ps
`default_nettype none
module hqs_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic [hqs_pkg::OP_W-1:0] operation,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    input  hqs_pkg::flags_t          flags,
    output hqs_pkg::cmd_t            cmd
);
    import hqs_pkg::*;

    step_t state_reg, state_next;
    logic  rsp_valid_reg, rsp_valid_next;
    logic  accept, load;
    op_t   op;

    assign op        = op_t'(operation);
    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign load      = (accept && (op == OP_APPEND || op == OP_CLEAR))
                       || state_reg == S_RD_WAIT || state_reg == S_DONE;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && op == OP_READ)
                begin
                    state_next = S_RD_WAIT;
                end
                else if (accept && op == OP_SORT)
                begin
                    state_next = S_START;
                end
            end
            S_RD_WAIT:    state_next = S_IDLE;
            S_START:      state_next = flags.count_lt2 ? S_DONE : S_SEG;
            S_SEG:
            begin
                if (!flags.seg_live)
                begin
                    state_next = S_POP;
                end
                else if (flags.seg_small)
                begin
                    state_next = S_INS_INIT;
                end
                else
                begin
                    state_next = S_PI_INIT;
                end
            end
            S_INS_INIT:   state_next = S_INS_OUTER;
            S_INS_OUTER:
            begin
                if (flags.ins_done)
                begin
                    state_next = flags.ret_seg ? S_SEG : S_POP;
                end
                else
                begin
                    state_next = S_INS_V;
                end
            end
            S_INS_V:      state_next = S_INS_CHK;
            S_INS_CHK:    state_next = flags.ins_more ? S_INS_CMP : S_INS_PUT;
            S_INS_CMP:    state_next = flags.ins_shift ? S_INS_CHK : S_INS_PUT;
            S_INS_PUT:    state_next = S_INS_OUTER;
            S_PI_INIT:    state_next = S_PI_PIV;
            S_PI_PIV:     state_next = S_SCAN_I;
            S_SCAN_I:     state_next = flags.i_lt_j ? S_SCAN_I_CMP : S_SCAN_END;
            S_SCAN_I_CMP: state_next = flags.rd_lt_pk ? S_SCAN_I : S_SCAN_J;
            S_SCAN_J:     state_next = flags.i_lt_j ? S_SCAN_J_CMP : S_SCAN_END;
            S_SCAN_J_CMP: state_next = flags.rd_gt_pk ? S_SCAN_J : S_SWAP;
            S_SWAP:       state_next = S_SWAP2;
            S_SWAP2:      state_next = S_SCAN_I;
            S_SCAN_END:   state_next = S_PEND_CMP;
            S_PEND_CMP:   state_next = flags.rd_ge_pk ? S_PSWAP : S_PREAD;
            S_PREAD:      state_next = S_PSWAP;
            S_PSWAP:      state_next = S_PSWAP2;
            S_PSWAP2:     state_next = S_SPLIT;
            S_SPLIT:
            begin
                if (flags.left && flags.right)
                begin
                    state_next = flags.q_full ? S_INS_INIT : S_SEG;
                end
                else if (flags.left || flags.right)
                begin
                    state_next = S_SEG;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_POP:        state_next = flags.q_empty ? S_DONE : S_POP_W;
            S_POP_W:      state_next = S_SEG;
            S_DONE:       state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign cmd.step   = state_reg;
    assign cmd.accept = accept;

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!rsp_valid_reg || rsp_ready))
        else $error("result loaded over an untaken beat");
    a_sort_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_SORT) |=> !req_ready)
        else $error("request taken during sort");
    a_busy_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_RD_WAIT && state_reg != S_DONE
         && !$past(load)) |-> !load)
        else $error("result produced mid sort");
`endif
endmodule
`default_nettype wire
